FILE: hdl/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg: shared types for the k-th largest selector
// Data widths and the control group that the top level broadcasts to every
// cell of the sorting row.
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int DATA_W = 32;
    localparam int K_W    = 7;

    typedef logic signed [DATA_W-1:0] t_data;

    // Control broadcast along the row of cells
    typedef struct packed {
        logic  insert;  // take the key in this cycle
        logic  drain;   // shift every cell one place toward cell 0
        t_data key;     // value being inserted
    } t_cell_ctrl;

endpackage

FILE: hdl/kls_cell.sv
// ----------------------------------------------------------------------------
// kls_cell: one slot of the descending insertion row
// Holds one value, compares it with the broadcast key, takes the key or its
// upper neighbor's value when the key displaces it, or the lower one's on drain.
// ----------------------------------------------------------------------------
module kls_cell (
    input  logic               i_clk,
    input  kls_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_occupied,
    input  logic               i_prev_gt,
    input  kls_pkg::t_data     i_prev_val,
    input  kls_pkg::t_data     i_next_val,
    output logic               o_gt,
    output kls_pkg::t_data     o_val
);
    import kls_pkg::*;

    t_data r_val;
    t_data n_val;

    // An empty slot loses to any key
    assign o_gt  = !i_occupied || (i_ctrl.key > r_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.insert && o_gt) begin
            // push down: take the neighbor's value if it moved, else the key
            n_val = i_prev_gt ? i_prev_val : i_ctrl.key;
        end else if (i_ctrl.drain) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: hdl/kth_largest_selector_unit.sv
// ----------------------------------------------------------------------------
// kth_largest_selector_unit: streaming k-th largest value of a set
// Keeps the k largest values of the current set in a sorted row of cells and
// reports the smallest of them after the set's last beat has arrived.
// ----------------------------------------------------------------------------
// Values of a set arrive one beat at a time; the last beat carries
// end_of_set. A row of MAX_K cells holds the retained values in descending
// order: every input beat is compared against all cells at once and slotted
// in, the cells below it move down one place, and anything past rank k falls
// off the end. A beat without end_of_set is taken every cycle while no drain
// is under way. After the last beat of a set, the input stalls and the row
// shifts up one cell per cycle until the smallest retained value sits in cell
// 0, where it is loaded into the output register; a stalled output holds that
// load back. The store is emptied by zeroing the retained count, so there is
// no clearing pass. k_select of 0 acts as 1 and values above MAX_K act as
// MAX_K. If the set held fewer than k values, the result is the set minimum
// and fewer_than_k is set. Write k_select only between beats.
module kth_largest_selector_unit #(
    parameter int MAX_K = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [kls_pkg::K_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [kls_pkg::DATA_W-1:0] i_sample_value,
    input  logic                      i_end_of_set,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [kls_pkg::DATA_W-1:0] o_kth_value,
    output logic                      o_fewer_than_k
);
    import kls_pkg::*;

    localparam int CW = $clog2(MAX_K + 1);
    localparam int KW = (CW > K_W) ? CW : K_W;

    typedef enum logic {ST_RUN, ST_DRAIN} t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [K_W-1:0]   r_k_select;
    logic             r_fewer;
    logic             r_out_valid;
    t_data            r_kth_value;
    logic             r_fewer_out;

    logic             in_accept;
    logic             out_free;
    logic [KW-1:0]    k_ext;
    logic [KW-1:0]    k_eff;
    logic [KW:0]      count_inc;
    logic [KW:0]      count_new;
    t_cell_ctrl       ctrl;

    logic  [MAX_K-1:0] cell_gt;
    t_data             cell_val [MAX_K];

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Clamp k to 1..MAX_K
    assign k_ext = KW'(r_k_select);
    always_comb begin
        k_eff = k_ext;
        if (k_ext == '0) begin
            k_eff = KW'(1);
        end else if (k_ext > KW'(MAX_K)) begin
            k_eff = KW'(MAX_K);
        end
    end

    // Retained count after this beat: grow by one, drop the tail past k
    assign count_inc = (KW+1)'(r_count) + (KW+1)'(1);
    assign count_new = (count_inc > (KW+1)'(k_eff)) ? (KW+1)'(k_eff) : count_inc;

    assign ctrl.insert = in_accept;
    assign ctrl.drain  = (r_state == ST_DRAIN) && (r_count > CW'(1));
    assign ctrl.key    = i_sample_value;

    // Row of cells, cell 0 holds the largest value
    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        logic  prev_gt;
        t_data prev_val;
        t_data next_val;

        if (g == 0) begin : g_head
            assign prev_gt  = 1'b0;
            assign prev_val = cell_val[g];
        end else begin : g_body
            assign prev_gt  = cell_gt[g-1];
            assign prev_val = cell_val[g-1];
        end

        if (g == MAX_K - 1) begin : g_tail
            assign next_val = cell_val[g];
        end else begin : g_inner
            assign next_val = cell_val[g+1];
        end

        kls_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_occupied (CW'(g) < r_count),
            .i_prev_gt  (prev_gt),
            .i_prev_val (prev_val),
            .i_next_val (next_val),
            .o_gt       (cell_gt[g]),
            .o_val      (cell_val[g])
        );
    end

    // Sequencer, count, configuration and output register; the result
    // payload needs no reset and is only loaded together with its valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_count     <= '0;
            r_k_select  <= K_W'(1);
            r_fewer     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k_select <= i_cfg_wdata;
            end

            // drop the result once the consumer takes it
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_RUN: begin
                    if (in_accept) begin
                        r_count <= CW'(count_new);
                        if (i_end_of_set) begin
                            r_fewer <= (count_new < (KW+1)'(k_eff));
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (r_count > CW'(1)) begin
                        // advance the smallest retained value toward cell 0
                        r_count <= r_count - CW'(1);
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kth_value <= cell_val[0];
                        r_fewer_out <= r_fewer;
                        r_count     <= '0;
                        r_state     <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    assign o_in_stall     = (r_state == ST_DRAIN);
    assign o_out_valid    = r_out_valid;
    assign o_kth_value    = r_kth_value;
    assign o_fewer_than_k = r_fewer_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_beat_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_end_of_set) |=> (r_state == ST_DRAIN) && (r_count != '0))
        else $error("last beat of a set did not start the drain");

    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DRAIN))
        else $error("result appeared without a drain");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_K))
        else $error("retained count exceeds the row length");

endmodule
